// ===== sv/rcot_pkg.sv =====
// shared types and constants for the rms current meter with offset tracking
// no dependencies; used by rcot_front, rcot_back and the top level
package rcot_pkg;

	localparam int MAX_WINDOW_DEF = 65536;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 20;

	typedef enum logic [CFG_AW-1:0] {
		REG_LPF_DIVISOR,
		REG_TURNS_RATIO,
		REG_CALIBRATION,
		REG_BURDEN
	} reg_idx_t;

	localparam logic [15:0] LPF_DIVISOR_RST = 16'd1000;
	localparam logic [15:0] TURNS_RATIO_RST = 16'd2000;
	localparam logic [17:0] CALIBRATION_RST = 18'd65536;
	localparam logic [19:0] BURDEN_RST      = 20'd33000;

	typedef struct packed {
		logic [15:0] lpf_divisor;
		logic [15:0] turns_ratio;
		logic [17:0] calibration_q16;
		logic [19:0] burden_milliohm;
	} cfg_t;

	// item kinds after classification
	typedef enum logic [1:0] {
		KIND_CAL,
		KIND_CAL_END,
		KIND_MEAS,
		KIND_MEAS_END
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] sample_mv;
	} item_t;

	localparam logic [19:0] RMS_MAX     = 20'hFFFFF;
	localparam logic [23:0] CURRENT_MAX = 24'hFFFFFF;
	localparam logic [9:0]  MILLI       = 10'd1000;

	// shared divider: 64 bit dividend, 32 bit divisor
	localparam int DVD_W = 64;
	localparam int DEN_W = 32;
	localparam int DCNT_W = 7;

endpackage

// ===== sv/rcot_front.sv =====
// front end: accepts input beats, classifies them and queues them for the back end
// depends on rcot_pkg
module rcot_front
	import rcot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_cmd,
	input  logic [11:0] in_sample,
	input  logic        in_last,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	item_t       item_in;
	logic        push;

	always_comb begin
		unique case ({in_cmd, in_last})
			2'b00:   item_in.kind = KIND_CAL;
			2'b01:   item_in.kind = KIND_CAL_END;
			2'b10:   item_in.kind = KIND_MEAS;
			default: item_in.kind = KIND_MEAS_END;
		endcase
		item_in.sample_mv = in_sample;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

// ===== sv/rcot_back.sv =====
// back end: offset filter, window accumulation, shared divider, square root,
// current scaling and the output register; depends on rcot_pkg
module rcot_back
	import rcot_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] out_rms,
	output logic [23:0] out_cur,
	output logic        out_sat
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 2);
	localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WINDOW);

	typedef enum logic [3:0] {
		S_IDLE, S_ODIV, S_MAG, S_SQR, S_ACC, S_CLOAD, S_CDIV,
		S_MLOAD, S_MDIV, S_SQRT, S_MUL1, S_MUL2, S_MUL3, S_IDIV, S_OUT
	} state_t;

	state_t            state_q;
	logic [27:0]       off_q;
	logic [63:0]       sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [11:0]       sample_q;
	logic              neg_q;
	logic              last_q;
	logic              sat_q;
	logic [19:0]       mag_s1;
	logic [39:0]       sq_s2;
	logic [19:0]       rms_q;
	logic [35:0]       p1_q;
	logic [53:0]       b_q;
	logic [23:0]       cur_q;
	logic              state_out_valid_q;

	// shared restoring divider, one quotient bit a cycle
	logic [DEN_W-1:0]  div_rem_q;
	logic [DVD_W-1:0]  div_dvd_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DEN_W:0]    rem_sh;
	logic              rem_ge;
	logic [DEN_W:0]    rem_sub;
	logic [DEN_W-1:0]  rem_nx;
	logic [DVD_W-1:0]  dvd_nx;
	logic              div_done;

	// bit-pair square root
	logic [63:0]       sq_v_q;
	logic [63:0]       sq_res_q;
	logic [63:0]       sq_bit_q;
	logic [63:0]       sq_t;
	logic              sq_ge;
	logic [63:0]       sq_res_nx;

	logic              in_range;
	logic [CNT_W-1:0]  n_win;
	logic [27:0]       s16;
	logic [27:0]       d_abs;
	logic [27:0]       s16_q;
	logic [27:0]       mag_abs;
	logic [27:0]       off_nx;
	logic [63:0]       b_milli;
	logic [15:0]       os_eff;

	assign rem_sh   = {div_rem_q, div_dvd_q[DVD_W-1]};
	assign rem_sub  = rem_sh - {1'b0, div_den_q};
	assign rem_ge   = (rem_sh >= {1'b0, div_den_q});
	assign rem_nx   = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
	assign dvd_nx   = {div_dvd_q[DVD_W-2:0], rem_ge};
	assign div_done = (div_cnt_q == DCNT_W'(1));

	assign sq_t      = sq_res_q + sq_bit_q;
	assign sq_ge     = (sq_v_q >= sq_t);
	assign sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

	assign in_range = (cnt_q < MAXW);
	assign n_win    = (cnt_q > MAXW) ? MAXW : cnt_q;
	assign s16      = {q_item.sample_mv, 16'd0};
	assign d_abs    = (s16 >= off_q) ? (s16 - off_q) : (off_q - s16);
	assign s16_q    = {sample_q, 16'd0};
	assign mag_abs  = (s16_q >= off_q) ? (s16_q - off_q) : (off_q - s16_q);
	assign off_nx   = neg_q ? (off_q - dvd_nx[27:0]) : (off_q + dvd_nx[27:0]);
	assign b_milli  = 64'(b_q) * 64'(MILLI);
	assign os_eff   = (cfg.lpf_divisor == 16'd0) ? 16'd1 : cfg.lpf_divisor;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = state_out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			off_q             <= '0;
			sum_q             <= '0;
			cnt_q             <= '0;
			state_out_valid_q <= 1'b0;
			div_cnt_q         <= '0;
		end else begin
			if (state_out_valid_q && out_ready && state_q != S_OUT)
				state_out_valid_q <= 1'b0;
			if (state_q == S_ODIV || state_q == S_CDIV || state_q == S_MDIV
				|| state_q == S_IDIV) begin
				div_rem_q <= rem_nx;
				div_dvd_q <= dvd_nx;
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						sample_q <= q_item.sample_mv;
						unique case (q_item.kind)
							KIND_CAL, KIND_CAL_END: begin
								if (in_range) begin
									cnt_q <= cnt_q + CNT_W'(1);
									sum_q <= sum_q + 64'(q_item.sample_mv);
								end else begin
									cnt_q <= MAXW + CNT_W'(1);
								end
								state_q <= (q_item.kind == KIND_CAL_END) ? S_CLOAD : S_IDLE;
							end
							default: begin
								last_q    <= (q_item.kind == KIND_MEAS_END);
								neg_q     <= (s16 < off_q);
								div_rem_q <= '0;
								div_dvd_q <= {d_abs, 36'd0};
								div_den_q <= DEN_W'(os_eff);
								div_cnt_q <= DCNT_W'(28);
								state_q   <= S_ODIV;
							end
						endcase
					end
				end
				S_ODIV: begin
					if (div_done) begin
						off_q   <= off_nx;
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					mag_s1  <= mag_abs[27:8];
					state_q <= S_SQR;
				end
				S_SQR: begin
					sq_s2   <= 40'(mag_s1) * 40'(mag_s1);
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (in_range) begin
						cnt_q <= cnt_q + CNT_W'(1);
						sum_q <= sum_q + 64'(sq_s2);
					end else begin
						cnt_q <= MAXW + CNT_W'(1);
					end
					state_q <= last_q ? S_MLOAD : S_IDLE;
				end
				S_CLOAD: begin
					div_rem_q <= '0;
					div_dvd_q <= {sum_q[47:0], 16'd0};
					div_den_q <= DEN_W'(n_win);
					div_cnt_q <= DCNT_W'(64);
					sum_q     <= '0;
					cnt_q     <= '0;
					state_q   <= S_CDIV;
				end
				S_CDIV: begin
					if (div_done) begin
						off_q   <= dvd_nx[27:0];
						state_q <= S_IDLE;
					end
				end
				S_MLOAD: begin
					sat_q     <= (cnt_q > MAXW);
					div_rem_q <= '0;
					div_dvd_q <= sum_q;
					div_den_q <= DEN_W'(n_win);
					div_cnt_q <= DCNT_W'(64);
					sum_q     <= '0;
					cnt_q     <= '0;
					state_q   <= S_MDIV;
				end
				S_MDIV: begin
					if (div_done) begin
						sq_v_q   <= dvd_nx;
						sq_res_q <= '0;
						sq_bit_q <= 64'd1 << 62;
						state_q  <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_ge) sq_v_q <= sq_v_q - sq_t;
					sq_res_q <= sq_res_nx;
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						if (sq_res_nx > 64'(RMS_MAX)) begin
							rms_q <= RMS_MAX;
							sat_q <= 1'b1;
						end else begin
							rms_q <= sq_res_nx[19:0];
						end
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					p1_q    <= 36'(rms_q) * 36'(cfg.turns_ratio);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					b_q     <= 54'(p1_q) * 54'(cfg.calibration_q16);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					if (cfg.burden_milliohm == 20'd0) begin
						cur_q   <= CURRENT_MAX;
						sat_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						// floor(b*1000 / (burden << 24))
						div_rem_q <= '0;
						div_dvd_q <= {b_milli[63:24], 24'd0};
						div_den_q <= DEN_W'(cfg.burden_milliohm);
						div_cnt_q <= DCNT_W'(40);
						state_q   <= S_IDIV;
					end
				end
				S_IDIV: begin
					if (div_done) begin
						if (dvd_nx[39:24] != 16'd0) begin
							cur_q <= CURRENT_MAX;
							sat_q <= 1'b1;
						end else begin
							cur_q <= dvd_nx[23:0];
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!state_out_valid_q || out_ready) begin
						state_out_valid_q <= 1'b1;
						out_rms           <= rms_q;
						out_cur           <= cur_q;
						out_sat           <= sat_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXW + CNT_W'(1))
		else $error("window count out of range");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ODIV || state_q == S_CDIV || state_q == S_MDIV || state_q == S_IDIV)
		|-> div_cnt_q != '0)
		else $error("divider running with no steps left");
	a_win_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOAD || state_q == S_MLOAD) |=> (sum_q == '0 && cnt_q == '0))
		else $error("window not cleared at its end");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != S_OUT)
		else $error("result stage entered straight from a pop");
`endif

endmodule

// ===== sv/rms_current_with_offset_tracking.sv =====
// top level of the true-rms current meter with dc offset tracking
// depends on rcot_pkg, rcot_front and rcot_back
//
// Samples arrive as beats of ADC millivolts; tuser selects calibration (0) or
// measurement (1) and tlast closes the phase or window. Calibration beats are
// summed and the closing beat sets the DC offset to their mean (Q12.16), with
// no result beat. Measurement beats pull the offset toward the sample by a
// first-order low-pass (divisor lpf_divisor, 0 acts as 1) and accumulate the
// square of the offset-removed value (Q12.8). The closing measurement beat
// gives one result beat: rms in millivolts Q.8 and current in milliamps,
// rms * turns * cal / 2^16 * 1000 / burden, clamped, with a saturation flag for
// a clamped value, a zero burden or a window longer than MAX_WINDOW (the extra
// samples still move the offset but are not summed). Steps: a measurement beat
// is popped, then runs the 28 steps of the shared one-bit-a-cycle divider and
// the magnitude, square and accumulate states; an ordinary calibration beat is
// only popped, its closing beat also loads and runs a 64-step divide. A closing
// measurement beat goes on with a load, 64 divide steps, 32 square-root steps,
// the multiply states, 40 more divide steps and the result state. A two-beat
// queue sits between the input side and the engine, and the result register
// lets the engine go on while a result waits. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module rms_current_with_offset_tracking
	import rcot_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [11:0] sample_mv, rest zero
	input  logic              s_axis_tuser,   // [0] cmd
	input  logic              s_axis_tlast,   // last sample of phase or window
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata,   // [19:0] rms_mv_q8, [43:20] current_ma
	output logic              m_axis_tuser,   // [0] saturated
	// configuration writes
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t        cfg_q;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	logic [19:0] rms;
	logic [23:0] cur;

	// register file, fields truncated to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lpf_divisor     <= LPF_DIVISOR_RST;
			cfg_q.turns_ratio     <= TURNS_RATIO_RST;
			cfg_q.calibration_q16 <= CALIBRATION_RST;
			cfg_q.burden_milliohm <= BURDEN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LPF_DIVISOR: cfg_q.lpf_divisor     <= cfg_wdata[15:0];
				REG_TURNS_RATIO: cfg_q.turns_ratio     <= cfg_wdata[15:0];
				REG_CALIBRATION: cfg_q.calibration_q16 <= cfg_wdata[17:0];
				default:         cfg_q.burden_milliohm <= cfg_wdata[19:0];
			endcase
		end
	end

	// accept and classify beats into the queue
	rcot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_sample (s_axis_tdata[11:0]),
		.in_last   (s_axis_tlast),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// offset filter, accumulation and result math
	rcot_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rms   (rms),
		.out_cur   (cur),
		.out_sat   (m_axis_tuser)
	);

	assign m_axis_tdata = {4'd0, cur, rms};

endmodule
